/* src/ffsic_pkg.sv */
// shared types and constants for the firmware file integrity checker
package ffsic_pkg;

  localparam int unsigned HdrLen = 24;

  localparam logic [23:0] OfsFileSum = 24'd17;
  localparam logic [23:0] OfsAttr    = 24'd19;
  localparam logic [23:0] OfsSize0   = 24'd20;
  localparam logic [23:0] OfsSize1   = 24'd21;
  localparam logic [23:0] OfsSize2   = 24'd22;
  localparam logic [23:0] OfsState   = 24'd23;
  localparam logic [23:0] HdrLast    = 24'(HdrLen - 1);
  localparam logic [23:0] HdrSize    = 24'(HdrLen);

  localparam logic [7:0] AttrChecksum = 8'h40;
  localparam logic [7:0] FixedSum     = 8'hAA;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BLANK      = 3'd1,
    ST_HDR_BAD    = 3'd2,
    ST_DATA_BAD   = 3'd3,
    ST_FIXED_BAD  = 3'd4,
    ST_SIZE_SMALL = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_of_file;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [23:0] file_size;
  } out_item_t;

endpackage

/* src/ffs_file_integrity_checker.sv */
// top level: byte stream in, one verdict per firmware file out
// Takes one file byte per cycle (one transfer on the input channel each clock, with no
// gaps of its own); the running header and data sums and the verdict decision sit in
// one combinational step between the accepted byte and the result register. A verdict
// is registered in the same cycle as the byte that settles it: after header byte 23,
// or after the last data byte when the checksum attribute is set. Input stalls only
// while a finished verdict waits in the result register and the output is held off.
// Bytes arriving with no file open and no start mark are dropped; a start mark
// abandons any file in progress. erase_polarity may be changed only while idle.
module ffs_file_integrity_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ffsic_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ffsic_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata
);

  logic                 erase_polarity;
  logic                 fire;
  logic                 res_valid;
  ffsic_pkg::out_item_t res_data;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  ffsic_scan u_scan (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .in_data        (in_data),
    .erase_polarity (erase_polarity),
    .res_valid      (res_valid),
    .res_data       (res_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      erase_polarity <= 1'b1;
    end else if (cfg_we) begin
      erase_polarity <= cfg_wdata;
    end
  end

  // result register, freed by an output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data <= res_data;
    end
  end

endmodule

/* src/ffsic_scan.sv */
// per-byte header and data scan with running sums and the verdict decision
module ffsic_scan (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  ffsic_pkg::in_item_t  in_data,
  input  logic                 erase_polarity,
  output logic                 res_valid,
  output ffsic_pkg::out_item_t res_data
);

  logic [23:0] byte_index, byte_index_next;
  logic [7:0]  header_sum, header_sum_next;
  logic [7:0]  data_sum, data_sum_next;
  logic [7:0]  stored_file_checksum, stored_file_checksum_next;
  logic [7:0]  attribute_bits, attribute_bits_next;
  logic [23:0] size_field, size_field_next;
  logic        all_blank, all_blank_next;
  logic        verdict_given, verdict_given_next;

  logic        start;
  logic        active;
  logic [7:0]  b;
  logic [7:0]  erased;
  logic [7:0]  data_total;
  logic        last_data;

  assign b      = in_data.byte_value;
  assign start  = in_data.start_of_file;
  assign active = fire && (start || !verdict_given);
  assign erased = erase_polarity ? 8'hFF : 8'h00;

  always_comb begin
    byte_index_next           = start ? 24'd0 : byte_index;
    header_sum_next           = start ? 8'd0 : header_sum;
    data_sum_next             = start ? 8'd0 : data_sum;
    stored_file_checksum_next = start ? 8'd0 : stored_file_checksum;
    attribute_bits_next       = start ? 8'd0 : attribute_bits;
    size_field_next           = start ? 24'd0 : size_field;
    all_blank_next            = start ? 1'b1 : all_blank;
    verdict_given_next        = start ? 1'b0 : verdict_given;
    res_valid                 = 1'b0;
    res_data.status           = ffsic_pkg::ST_OK;
    data_total                = 8'd0;
    last_data                 = 1'b0;

    if (byte_index_next < ffsic_pkg::HdrSize) begin
      if (b != erased) all_blank_next = 1'b0;
      if (byte_index_next != ffsic_pkg::OfsFileSum && byte_index_next != ffsic_pkg::OfsState)
        header_sum_next = header_sum_next + b;
      if (byte_index_next == ffsic_pkg::OfsFileSum) stored_file_checksum_next = b;
      if (byte_index_next == ffsic_pkg::OfsAttr) attribute_bits_next = b;
      if (byte_index_next == ffsic_pkg::OfsSize0) size_field_next[7:0] = b;
      if (byte_index_next == ffsic_pkg::OfsSize1) size_field_next[15:8] = b;
      if (byte_index_next == ffsic_pkg::OfsSize2) size_field_next[23:16] = b;

      if (byte_index_next == ffsic_pkg::HdrLast) begin
        if (all_blank_next) begin
          res_valid       = 1'b1;
          res_data.status = ffsic_pkg::ST_BLANK;
        end else if (header_sum_next != 8'd0) begin
          res_valid       = 1'b1;
          res_data.status = ffsic_pkg::ST_HDR_BAD;
        end else if ((attribute_bits_next & ffsic_pkg::AttrChecksum) != 8'd0) begin
          if (size_field_next < ffsic_pkg::HdrSize) begin
            res_valid       = 1'b1;
            res_data.status = ffsic_pkg::ST_SIZE_SMALL;
          end else if (size_field_next == ffsic_pkg::HdrSize) begin
            res_valid       = 1'b1;
            res_data.status = (stored_file_checksum_next == 8'd0) ?
                              ffsic_pkg::ST_OK : ffsic_pkg::ST_DATA_BAD;
          end
        end else begin
          res_valid       = 1'b1;
          res_data.status = (stored_file_checksum_next == ffsic_pkg::FixedSum) ?
                            ffsic_pkg::ST_OK : ffsic_pkg::ST_FIXED_BAD;
        end
      end
    end else begin
      data_sum_next = data_sum_next + b;
      data_total    = data_sum_next + stored_file_checksum_next;
      last_data     = ({1'b0, byte_index_next} + 25'd1) >= {1'b0, size_field_next};
      if (last_data) begin
        res_valid       = 1'b1;
        res_data.status = (data_total == 8'd0) ? ffsic_pkg::ST_OK : ffsic_pkg::ST_DATA_BAD;
      end
    end

    res_data.file_size = size_field_next;
    byte_index_next    = byte_index_next + 24'd1;
    if (res_valid) verdict_given_next = 1'b1;
    res_valid = res_valid && active;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index           <= 24'd0;
      header_sum           <= 8'd0;
      data_sum             <= 8'd0;
      stored_file_checksum <= 8'd0;
      attribute_bits       <= 8'd0;
      size_field           <= 24'd0;
      all_blank            <= 1'b1;
      verdict_given        <= 1'b1;
    end else if (active) begin
      byte_index           <= byte_index_next;
      header_sum           <= header_sum_next;
      data_sum             <= data_sum_next;
      stored_file_checksum <= stored_file_checksum_next;
      attribute_bits       <= attribute_bits_next;
      size_field           <= size_field_next;
      all_blank            <= all_blank_next;
      verdict_given        <= verdict_given_next;
    end
  end

endmodule
